// ===== rtl/rlba_pkg.sv =====
// ----------------------------------------------------------------------------
// rlba_pkg: shared types and codes of the run-list block allocator
// Beat layouts of the request and result channels and their field codes.
// ----------------------------------------------------------------------------
`default_nettype none

package rlba_pkg;

  localparam int CORE_W  = 2;
  localparam int COUNT_W = 7;
  localparam int BLOCK_W = 10;

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_SHORT = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    kind_t               kind;
    logic [CORE_W-1:0]   core;
    logic [COUNT_W-1:0]  count;
    logic [BLOCK_W-1:0]  freed_block;
  } req_t;

  typedef struct packed {
    logic [BLOCK_W-1:0]  block_index;
    status_t             status;
    logic                last;
  } rsp_t;

endpackage

`default_nettype wire

// ===== rtl/rlba_stream_if.sv =====
// ----------------------------------------------------------------------------
// rlba_stream_if: valid/ready channel
// Carries one payload beat per cycle in which valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface rlba_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/rlba_run_store.sv =====
// ----------------------------------------------------------------------------
// rlba_run_store: free-run slot memory
// One synchronous memory of (start, length) entries addressed by core and
// slot, with registered reads. Slot zero of each core reads as the full initial
// run until it is first written.
// ----------------------------------------------------------------------------
`default_nettype none

module rlba_run_store #(
  parameter int NUM_CORES       = 4,
  parameter int BLOCKS_PER_CORE = 1024
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  input  wire logic                                      rd_en,
  input  wire logic [((NUM_CORES > 1) ? $clog2(NUM_CORES) : 1)-1:0] rd_core,
  input  wire logic [$clog2(BLOCKS_PER_CORE)-1:0]        rd_slot,
  output logic      [$clog2(BLOCKS_PER_CORE)-1:0]        rd_start,
  output logic      [$clog2(BLOCKS_PER_CORE+1)-1:0]      rd_len,
  input  wire logic                                      wr_en,
  input  wire logic [((NUM_CORES > 1) ? $clog2(NUM_CORES) : 1)-1:0] wr_core,
  input  wire logic [$clog2(BLOCKS_PER_CORE)-1:0]        wr_slot,
  input  wire logic [$clog2(BLOCKS_PER_CORE)-1:0]        wr_start,
  input  wire logic [$clog2(BLOCKS_PER_CORE+1)-1:0]      wr_len
);

  localparam int IW    = $clog2(BLOCKS_PER_CORE);
  localparam int CW    = $clog2(BLOCKS_PER_CORE + 1);
  localparam int DEPTH = ((NUM_CORES > 1) ? NUM_CORES : 2) << IW;

  logic [IW+CW-1:0]     mem [DEPTH];
  logic [IW+CW-1:0]     rd_data;
  logic                 rd_fresh;
  logic [NUM_CORES-1:0] fresh;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[{wr_core, wr_slot}] <= {wr_start, wr_len};
    end
    if (rd_en) begin
      rd_data  <= mem[{rd_core, rd_slot}];
      rd_fresh <= fresh[rd_core] && (rd_slot == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fresh <= '1;
    end else if (wr_en && (wr_slot == '0)) begin
      fresh[wr_core] <= 1'b0;
    end
  end

  assign rd_start = rd_fresh ? '0 : rd_data[IW+CW-1:CW];
  assign rd_len   = rd_fresh ? CW'(BLOCKS_PER_CORE) : rd_data[CW-1:0];

endmodule

`default_nettype wire

// ===== rtl/rlba_idx_reduce.sv =====
// ----------------------------------------------------------------------------
// rlba_idx_reduce: freed block index reduction
// Reduces a returned block index modulo the pool size with a reciprocal
// multiply and one correcting subtraction, staged through the x, q and result
// registers, and pulses done with the result, which is held until the next start.
// ----------------------------------------------------------------------------
`default_nettype none

module rlba_idx_reduce #(
  parameter int BLOCKS_PER_CORE = 1024
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  start,
  input  wire logic [rlba_pkg::BLOCK_W-1:0]          value,
  output logic                                       done,
  output logic      [$clog2(BLOCKS_PER_CORE)-1:0]    result
);

  localparam int BW = rlba_pkg::BLOCK_W;
  localparam int IW = $clog2(BLOCKS_PER_CORE);
  localparam int SH = 2 * BW;
  localparam int PW = BW + SH;
  localparam int RW = BW + 18;
  localparam logic [SH-1:0] RECIP = SH'((1 << SH) / BLOCKS_PER_CORE);

  logic [BW-1:0] x;
  logic [BW-1:0] q;
  logic          x_valid;
  logic          q_valid;
  logic [PW-1:0] prod;
  logic [RW-1:0] rem_raw;
  logic [RW-1:0] rem_fix;

  // The quotient estimate is exact or one short, so one subtraction corrects it.
  assign prod    = {{BW{1'b0}}, RECIP} * {{SH{1'b0}}, x};
  assign rem_raw = {{(RW-BW){1'b0}}, x}
                 - ({{(RW-BW){1'b0}}, q} * RW'(BLOCKS_PER_CORE));
  assign rem_fix = (rem_raw >= RW'(BLOCKS_PER_CORE)) ? rem_raw - RW'(BLOCKS_PER_CORE)
                                                     : rem_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_valid <= 1'b0;
      q_valid <= 1'b0;
      done    <= 1'b0;
    end else begin
      x_valid <= start;
      q_valid <= x_valid;
      done    <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= value;
    end
    if (x_valid) begin
      q <= prod[PW-1:SH];
    end
    if (q_valid) begin
      result <= rem_fix[IW-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/run_list_block_allocator_core.sv =====
// ----------------------------------------------------------------------------
// run_list_block_allocator_core: per-core fixed-size block allocator
// Allocation passes S_DECIDE and S_LOAD, then emits one result beat per cycle
// while the result channel takes them, with a further S_LOAD for each run walked;
// errors and empty requests answer from S_RESP; a free passes S_REDUCE, S_FREE, S_RESP.
// One request is in work at a time; the run memory read port sets the pace.
// Reset restores every pool to one full run at once, with no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module run_list_block_allocator_core #(
  parameter int NUM_CORES       = 4,
  parameter int BLOCKS_PER_CORE = 1024,
  parameter int MAX_ALLOC       = 64
) (
  input wire logic     clk,
  input wire logic     rst,
  rlba_stream_if.sink   req,
  rlba_stream_if.source rsp
);

  localparam int IW    = $clog2(BLOCKS_PER_CORE);
  localparam int CW    = $clog2(BLOCKS_PER_CORE + 1);
  localparam int CRW   = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
  localparam int BW    = rlba_pkg::BLOCK_W;
  localparam int CNT_W = rlba_pkg::COUNT_W;
  localparam int CRI_W = rlba_pkg::CORE_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_REDUCE,
    S_FREE,
    S_RESP,
    S_LOAD,
    S_EMIT
  } state_t;

  state_t                  state;
  rlba_pkg::kind_t         kind;
  logic [CRW-1:0]          core_idx;
  logic                    core_ok;
  logic [CNT_W-1:0]        count;
  logic [BW-1:0]           freed;
  rlba_pkg::status_t       resp_status;
  logic [CNT_W-1:0]        remaining;
  logic [IW-1:0]           run_st;
  logic [CW-1:0]           run_len;
  logic [IW-1:0]           head [NUM_CORES];
  logic [IW-1:0]           tail [NUM_CORES];
  logic [CW-1:0]           free_cnt [NUM_CORES];
  logic                    out_valid;
  rlba_pkg::rsp_t          out_q;

  logic                    can_push;
  logic                    beat_load;
  logic [CRW+CRI_W-1:0]    core_w;
  logic [IW-1:0]           cur_head;
  logic [IW-1:0]           cur_tail;
  logic [CW-1:0]           cur_free;
  logic [CW+CNT_W-1:0]     count_ext;
  logic [CW+CNT_W-1:0]     free_ext;
  logic                    pool_full;
  logic                    too_many;
  logic [IW+BW-1:0]        st_ext;

  logic                    rd_en;
  logic [IW-1:0]           rd_slot;
  logic [IW-1:0]           rd_start;
  logic [CW-1:0]           rd_len;
  logic                    wr_en;
  logic [IW-1:0]           wr_slot;
  logic [IW-1:0]           wr_start;
  logic [CW-1:0]           wr_len;
  logic                    red_start;
  logic                    red_done;
  logic [IW-1:0]           red_result;

  function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] s);
    return (s == IW'(BLOCKS_PER_CORE - 1)) ? '0 : s + 1'b1;
  endfunction

  assign core_w    = {{CRW{1'b0}}, req.payload.core};
  assign can_push  = !out_valid || rsp.ready;
  assign beat_load = ((state == S_RESP) || (state == S_EMIT)) && can_push;
  assign cur_head  = head[core_idx];
  assign cur_tail  = tail[core_idx];
  assign cur_free  = free_cnt[core_idx];
  assign count_ext = {{CW{1'b0}}, count};
  assign free_ext  = {{CNT_W{1'b0}}, cur_free};
  assign pool_full = (cur_free == CW'(BLOCKS_PER_CORE));
  assign too_many  = (count > CNT_W'(MAX_ALLOC)) || (count_ext > free_ext);
  assign st_ext    = {{BW{1'b0}}, run_st};

  assign req.ready   = (state == S_IDLE);
  assign rsp.valid   = out_valid;
  assign rsp.payload = out_q;

  always_comb begin
    rd_en     = 1'b0;
    rd_slot   = cur_head;
    wr_en     = 1'b0;
    wr_slot   = cur_tail;
    wr_start  = red_result;
    wr_len    = CW'(1);
    red_start = 1'b0;
    unique case (state)
      S_DECIDE: begin
        if (core_ok) begin
          if (kind == rlba_pkg::KIND_FREE) begin
            red_start = !pool_full;
          end else begin
            rd_en = (count != '0) && !too_many;
          end
        end
      end
      S_FREE: begin
        wr_en = 1'b1;
      end
      S_EMIT: begin
        if (can_push) begin
          if (remaining == CNT_W'(1)) begin
            if (run_len != CW'(1)) begin
              wr_en    = 1'b1;
              wr_slot  = cur_head;
              wr_start = run_st + 1'b1;
              wr_len   = run_len - 1'b1;
            end
          end else if (run_len == CW'(1)) begin
            rd_en   = 1'b1;
            rd_slot = next_slot(cur_head);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      for (int c = 0; c < NUM_CORES; c++) begin
        head[c]     <= '0;
        tail[c]     <= next_slot('0);
        free_cnt[c] <= CW'(BLOCKS_PER_CORE);
      end
    end else begin
      if (beat_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            kind     <= req.payload.kind;
            core_idx <= core_w[CRW-1:0];
            core_ok  <= (core_w < (CRW + CRI_W)'(NUM_CORES));
            count    <= req.payload.count;
            freed    <= req.payload.freed_block;
            state    <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (!core_ok) begin
            resp_status <= (kind == rlba_pkg::KIND_FREE) ? rlba_pkg::STATUS_FULL
                                                         : rlba_pkg::STATUS_SHORT;
            state       <= S_RESP;
          end else if (kind == rlba_pkg::KIND_FREE) begin
            if (pool_full) begin
              resp_status <= rlba_pkg::STATUS_FULL;
              state       <= S_RESP;
            end else begin
              state <= S_REDUCE;
            end
          end else if (count == '0) begin
            resp_status <= rlba_pkg::STATUS_OK;
            state       <= S_RESP;
          end else if (too_many) begin
            resp_status <= rlba_pkg::STATUS_SHORT;
            state       <= S_RESP;
          end else begin
            remaining <= count;
            state     <= S_LOAD;
          end
        end
        S_REDUCE: begin
          if (red_done) begin
            state <= S_FREE;
          end
        end
        S_FREE: begin
          tail[core_idx]     <= next_slot(cur_tail);
          free_cnt[core_idx] <= cur_free + 1'b1;
          resp_status        <= rlba_pkg::STATUS_OK;
          state              <= S_RESP;
        end
        S_RESP: begin
          if (can_push) begin
            out_q.block_index <= '0;
            out_q.status      <= resp_status;
            out_q.last        <= 1'b1;
            state             <= S_IDLE;
          end
        end
        S_LOAD: begin
          run_st  <= rd_start;
          run_len <= rd_len;
          state   <= S_EMIT;
        end
        S_EMIT: begin
          if (can_push) begin
            out_q.block_index  <= st_ext[BW-1:0];
            out_q.status       <= rlba_pkg::STATUS_OK;
            out_q.last         <= (remaining == CNT_W'(1));
            free_cnt[core_idx] <= cur_free - 1'b1;
            remaining          <= remaining - 1'b1;
            run_st             <= run_st + 1'b1;
            run_len            <= run_len - 1'b1;
            if (run_len == CW'(1)) begin
              head[core_idx] <= next_slot(cur_head);
            end
            if (remaining == CNT_W'(1)) begin
              state <= S_IDLE;
            end else if (run_len == CW'(1)) begin
              state <= S_LOAD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  rlba_run_store #(
    .NUM_CORES       (NUM_CORES),
    .BLOCKS_PER_CORE (BLOCKS_PER_CORE)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (rd_en),
    .rd_core  (core_idx),
    .rd_slot  (rd_slot),
    .rd_start (rd_start),
    .rd_len   (rd_len),
    .wr_en    (wr_en),
    .wr_core  (core_idx),
    .wr_slot  (wr_slot),
    .wr_start (wr_start),
    .wr_len   (wr_len)
  );

  rlba_idx_reduce #(
    .BLOCKS_PER_CORE (BLOCKS_PER_CORE)
  ) u_reduce (
    .clk    (clk),
    .rst    (rst),
    .start  (red_start),
    .value  (freed),
    .done   (red_done),
    .result (red_result)
  );

endmodule

`default_nettype wire

// ===== rtl/rlba_checker.sv =====
// ----------------------------------------------------------------------------
// rlba_checker: port-level checks of the block allocator
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rlba_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           req_valid,
  input wire logic           req_ready,
  input wire logic           rsp_valid,
  input wire logic           rsp_ready,
  input wire rlba_pkg::rsp_t rsp_payload
);

  // Only one request is in work, so an accepted beat closes the request side.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while another was in work");

  a_error_is_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_payload.status != rlba_pkg::STATUS_OK) |-> rsp_payload.last)
    else $error("error result without last");

  a_error_no_index: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_payload.status != rlba_pkg::STATUS_OK)
      |-> (rsp_payload.block_index == '0))
    else $error("error result carries a block index");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
    else $error("stalled result beat changed");

endmodule

bind run_list_block_allocator_core rlba_checker u_chk (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_payload (rsp.payload)
);

`default_nettype wire

// ===== sim/run_list_block_allocator_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// run_list_block_allocator_core_test: self-checking bench of the block allocator
// Requests go in through a queue-fed driver and result beats are checked by a
// monitor against a behavioral copy of the per-core free run lists. It covers
// pool drain, fragmented multi-run walks, errors and random idling on both ends.
// ----------------------------------------------------------------------------
module run_list_block_allocator_core_test;

  localparam int NUM_CORES   = 4;
  localparam int BLOCKS      = 1024;
  localparam int MAX_ALLOC   = 64;
  localparam int RANDOM_REQS = 370;
  localparam int STALL_LIMIT = 5000;
  localparam int BLK_W       = rlba_pkg::BLOCK_W;
  localparam int CRE_W       = rlba_pkg::CORE_W;
  localparam int CNT_W       = rlba_pkg::COUNT_W;

  logic clk;
  logic rst;

  rlba_stream_if #(.payload_t(rlba_pkg::req_t)) req_if ();
  rlba_stream_if #(.payload_t(rlba_pkg::rsp_t)) rsp_if ();

  run_list_block_allocator_core #(
    .NUM_CORES      (NUM_CORES),
    .BLOCKS_PER_CORE(BLOCKS),
    .MAX_ALLOC      (MAX_ALLOC)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  // Free run lists of every core, kept in circular slot stores.
  logic [BLK_W-1:0] run_first [NUM_CORES][BLOCKS];
  logic [10:0]      run_len   [NUM_CORES][BLOCKS];
  logic [BLK_W-1:0] pool_head [NUM_CORES];
  logic [BLK_W-1:0] pool_tail [NUM_CORES];
  logic [10:0]      pool_runs [NUM_CORES];
  logic [10:0]      pool_avail[NUM_CORES];

  rlba_pkg::req_t pending_reqs[$];
  rlba_pkg::rsp_t owed_beats[$];
  rlba_pkg::rsp_t want;
  int             gen_avail[NUM_CORES];

  bit          failed;
  bit          draining;
  int unsigned send_wait, send_burst, stall_left, recv_burst, idle_cycles;
  int unsigned n_reqs, n_granted, n_released, n_short, n_full, max_walk;

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic void pool_reset();
    for (int c = 0; c < NUM_CORES; c++) begin
      for (int s = 0; s < BLOCKS; s++) begin
        run_first[c][s] = '0;
        run_len[c][s]   = '0;
      end
      run_len[c][0] = 11'(BLOCKS);
      pool_head[c]  = '0;
      pool_tail[c]  = 10'd1;
      pool_runs[c]  = 11'd1;
      pool_avail[c] = 11'(BLOCKS);
    end
  endfunction

  function automatic void serve_request(rlba_pkg::req_t r);
    int unsigned      c, left, take, walked;
    logic [BLK_W-1:0] st;
    logic [10:0]      len;
    rlba_pkg::rsp_t   beat;
    c      = r.core;
    walked = 0;
    beat.block_index = '0;
    beat.status      = rlba_pkg::STATUS_OK;
    beat.last        = 1'b1;
    if (r.kind == rlba_pkg::KIND_FREE) begin
      if (pool_avail[c] >= BLOCKS) begin
        beat.status = rlba_pkg::STATUS_FULL;
        n_full++;
      end else begin
        run_first[c][pool_tail[c]] = BLK_W'(r.freed_block % BLOCKS);
        run_len[c][pool_tail[c]]   = 11'd1;
        pool_tail[c]  = pool_tail[c] + 1'b1;
        pool_runs[c]  = pool_runs[c] + 1'b1;
        pool_avail[c] = pool_avail[c] + 1'b1;
        n_released++;
      end
      owed_beats.push_back(beat);
    end else if (r.count == 0) begin
      owed_beats.push_back(beat);
    end else if (r.count > MAX_ALLOC || r.count > pool_avail[c]) begin
      beat.status = rlba_pkg::STATUS_SHORT;
      n_short++;
      owed_beats.push_back(beat);
    end else begin
      left = r.count;
      while (left > 0 && pool_runs[c] > 0) begin
        st   = run_first[c][pool_head[c]];
        len  = run_len[c][pool_head[c]];
        take = (left <= len) ? left : len;
        for (int unsigned i = 0; i < take; i++) begin
          beat.block_index = BLK_W'(st + i);
          beat.last        = (left - i == 1);
          owed_beats.push_back(beat);
        end
        left          = left - take;
        pool_avail[c] = pool_avail[c] - 11'(take);
        n_granted    += take;
        walked++;
        if (len > take) begin
          run_first[c][pool_head[c]] = BLK_W'(st + take);
          run_len[c][pool_head[c]]   = 11'(len - take);
        end else begin
          pool_head[c] = pool_head[c] + 1'b1;
          pool_runs[c] = pool_runs[c] - 1'b1;
        end
      end
      if (walked > max_walk) max_walk = walked;
    end
  endfunction

  function automatic void add_req(rlba_pkg::kind_t k, int core, int count, int blk);
    rlba_pkg::req_t r;
    r.kind        = k;
    r.core        = CRE_W'(core);
    r.count       = CNT_W'(count);
    r.freed_block = BLK_W'(blk);
    pending_reqs.push_back(r);
    if (k == rlba_pkg::KIND_FREE) begin
      if (gen_avail[core] < BLOCKS) gen_avail[core]++;
    end else if (count >= 1 && count <= MAX_ALLOC && count <= gen_avail[core]) begin
      gen_avail[core] -= count;
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        serve_request(req_if.payload);
        n_reqs++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (send_wait != 0 || pending_reqs.size() == 0) begin
          if (send_wait != 0) send_wait--;
          req_if.valid <= 1'b0;
        end else begin
          req_if.payload <= pending_reqs.pop_front();
          req_if.valid   <= 1'b1;
          if (send_burst != 0) begin
            send_burst--;
            send_wait = 0;
          end else begin
            send_wait = pick_gap();
            if ($urandom_range(99) < 4) send_burst = $urandom_range(20, 60);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (owed_beats.size() == 0) begin
          $display("%0t: unexpected beat block_index %0d status %0d last %0d", $time,
                   rsp_if.payload.block_index, rsp_if.payload.status, rsp_if.payload.last);
          failed = 1'b1;
        end else begin
          want = owed_beats.pop_front();
          if (rsp_if.payload.block_index !== want.block_index) begin
            $display("%0t: block_index expected %0d actual %0d", $time,
                     want.block_index, rsp_if.payload.block_index);
            failed = 1'b1;
          end
          if (rsp_if.payload.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     want.status, rsp_if.payload.status);
            failed = 1'b1;
          end
          if (rsp_if.payload.last !== want.last) begin
            $display("%0t: last expected %0d actual %0d", $time,
                     want.last, rsp_if.payload.last);
            failed = 1'b1;
          end
        end
      end
      if (draining) begin
        rsp_if.ready <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
        if (recv_burst != 0) begin
          recv_burst--;
        end else begin
          stall_left = pick_gap();
          if ($urandom_range(99) < 4) recv_burst = $urandom_range(20, 60);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
          $display("run_list_block_allocator_core verification failed");
          $finish;
        end
      end
    end
  end

  initial begin
    int c, roll, cap, count;
    rst            = 1'b1;
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    rsp_if.ready   = 1'b0;
    failed         = 1'b0;
    draining       = 1'b0;
    pool_reset();
    for (int k = 0; k < NUM_CORES; k++) gen_avail[k] = BLOCKS;

    // Free into a full pool, empty and oversized allocations.
    add_req(rlba_pkg::KIND_FREE, 0, 0, 5);
    add_req(rlba_pkg::KIND_ALLOC, 0, 0, 0);
    add_req(rlba_pkg::KIND_ALLOC, 0, MAX_ALLOC + 1, 0);
    add_req(rlba_pkg::KIND_ALLOC, 0, 127, 1023);
    // Drain core 3, hit the shortage, then refill it with single-block runs,
    // including a double free, and allocate across all three runs.
    for (int k = 0; k < BLOCKS / MAX_ALLOC; k++) begin
      add_req(rlba_pkg::KIND_ALLOC, 3, MAX_ALLOC, 0);
    end
    add_req(rlba_pkg::KIND_ALLOC, 3, 1, 0);
    add_req(rlba_pkg::KIND_FREE, 3, 0, 1023);
    add_req(rlba_pkg::KIND_FREE, 3, 0, 1023);
    add_req(rlba_pkg::KIND_FREE, 3, 0, 0);
    add_req(rlba_pkg::KIND_ALLOC, 3, 3, 0);

    for (int k = 0; k < RANDOM_REQS; k++) begin
      c    = ($urandom_range(99) < 35) ? 3 : $urandom_range(0, 2);
      roll = $urandom_range(99);
      if (roll < 3) begin
        add_req(rlba_pkg::KIND_ALLOC, c, $urandom_range(MAX_ALLOC + 1, 127),
                $urandom_range(1023));
      end else if (roll < 5) begin
        add_req(rlba_pkg::KIND_ALLOC, c, 0, $urandom_range(1023));
      end else if (roll < 8 || (gen_avail[c] < BLOCKS && roll < 50)) begin
        add_req(rlba_pkg::KIND_FREE, c, $urandom_range(127), $urandom_range(1023));
      end else begin
        roll = $urandom_range(99);
        if (roll < 60)      count = $urandom_range(1, 8);
        else if (roll < 90) count = $urandom_range(9, MAX_ALLOC - 1);
        else                count = MAX_ALLOC;
        cap = gen_avail[c] + 2;
        if (cap < MAX_ALLOC && $urandom_range(99) < 70) count = $urandom_range(1, cap);
        add_req(rlba_pkg::KIND_ALLOC, c, count, $urandom_range(1023));
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    while (pending_reqs.size() != 0 || req_if.valid) @(posedge clk);
    while (owed_beats.size() != 0) @(posedge clk);
    draining = 1'b1;
    repeat (40) @(posedge clk);

    $display("Ran %0d requests: %0d blocks handed out, %0d blocks returned.",
             n_reqs, n_granted, n_released);
    $display("Saw %0d shortage and %0d full-pool errors; longest walk crossed %0d runs.",
             n_short, n_full, max_walk);
    if (!failed) begin
      $display("run_list_block_allocator_core verification clean");
    end else begin
      $display("run_list_block_allocator_core verification failed");
    end
    $finish;
  end

endmodule
